// ===== hw/rtl/tlr_pkg.sv =====
// Types and constants of the track linear resampler.
// Used by every module in hw/rtl; depends on nothing.
package tlr_pkg;

  localparam int unsigned ResultLimit = 62;
  localparam int unsigned CntW = 6;
  localparam int unsigned ProdW = 65;
  localparam int unsigned DivCntW = 7;

  typedef struct packed {
    logic [31:0] point_time;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic new_track;
  } in_t;

  typedef struct packed {
    logic [31:0] out_time;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic point_kind;
    logic gap_clipped;
    logic last_of_run;
  } out_t;

  // One segment for the back end to carry out.
  typedef struct packed {
    logic [31:0] prev_time;
    logic [31:0] prev_x;
    logic [31:0] prev_y;
    logic [31:0] cur_time;
    logic [31:0] cur_x;
    logic [31:0] cur_y;
    logic emit_first;
    logic clipped;
    logic [CntW-1:0] n_interp;
  } job_t;

endpackage

// ===== hw/rtl/track_linear_resampler.sv =====
// Top level of the track linear resampler.
// Depends on tlr_pkg, tlr_front, tlr_job_fifo and tlr_back.
//
// Usage:
//   Input queue: present a point on point_i with push high; it is taken on
//   a clock edge where full is low. new_track starts a new track.
//   Result queue: while empty is low, result_o holds the oldest result;
//   raise pop to take it. last_of_run marks the last result of a segment.
//   A lone point (first of a track) is stored and produces no result.
//   Order: a point is classified in the cycle it is taken; the back end
//   takes a segment job, then sends out each original point from its own
//   state and builds each interpolated point in the setup states StDcalc,
//   StMulX and StMulY, the bit-serial dividers (x and y run together) and
//   an output state.
//   Up to two segments wait in the job queue, so input is taken while the
//   back end works; full rises only when that queue is full.
//   A stalled receiver holds the result register; the back end then waits.
//   Reset clears the held point and empties both queues.
module track_linear_resampler #(
  parameter int unsigned MaxGap = 60
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  tlr_pkg::in_t  point_i,
  output logic          empty,
  input  logic          pop,
  output tlr_pkg::out_t result_o
);

  tlr_pkg::job_t fr_job, fifo_job;
  logic fr_push, fifo_full, fifo_empty, fifo_pop;

  tlr_front #(.MaxGap(MaxGap)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .point_i,
    .job_full_i(fifo_full), .full_o(full),
    .job_push_o(fr_push), .job_o(fr_job)
  );

  tlr_job_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(fr_push), .data_i(fr_job),
    .pop_i(fifo_pop), .full_o(fifo_full), .empty_o(fifo_empty), .data_o(fifo_job)
  );

  tlr_back u_back (
    .clk_i, .rst_ni,
    .job_empty_i(fifo_empty), .job_i(fifo_job), .job_pop_o(fifo_pop),
    .pop_i(pop), .empty_o(empty), .result_o
  );

endmodule

// ===== hw/rtl/tlr_front.sv =====
// Front end: accepts points, holds the previous point, sizes each segment.
// Depends on tlr_pkg.
module tlr_front #(
  parameter int unsigned MaxGap = 60
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tlr_pkg::in_t  point_i,
  input  logic          job_full_i,
  output logic          full_o,
  output logic          job_push_o,
  output tlr_pkg::job_t job_o
);

  logic        have_prev_q, first_sent_q;
  logic [31:0] prev_time_q, prev_x_q, prev_y_q;
  logic        accept, lone;
  logic [16:0] s0p1, s1, raw_n;
  logic [6:0]  room, cap;
  logic        clipped;

  assign accept = push_i && !job_full_i;
  assign full_o = job_full_i;
  assign lone   = point_i.new_track || !have_prev_q;

  always_comb begin
    s0p1  = {1'b0, prev_time_q[31:16]} + 17'd1;
    s1    = {1'b0, point_i.point_time[31:16]};
    raw_n = (s1 > s0p1) ? (s1 - s0p1) : 17'd0;
    room  = 7'(tlr_pkg::ResultLimit - 1) - {6'd0, !first_sent_q};
    cap   = (7'(MaxGap) > room) ? room : 7'(MaxGap);
    clipped = raw_n > {10'd0, cap};
  end

  assign job_push_o = accept && !lone;

  always_comb begin
    job_o.prev_time  = prev_time_q;
    job_o.prev_x     = prev_x_q;
    job_o.prev_y     = prev_y_q;
    job_o.cur_time   = point_i.point_time;
    job_o.cur_x      = point_i.point_x;
    job_o.cur_y      = point_i.point_y;
    job_o.emit_first = !first_sent_q;
    job_o.clipped    = clipped;
    job_o.n_interp   = clipped ? cap[tlr_pkg::CntW-1:0] : raw_n[tlr_pkg::CntW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q  <= 1'b0;
      first_sent_q <= 1'b0;
      prev_time_q  <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
    end else if (accept) begin
      have_prev_q  <= 1'b1;
      first_sent_q <= !lone;
      prev_time_q  <= point_i.point_time;
      prev_x_q     <= point_i.point_x;
      prev_y_q     <= point_i.point_y;
    end
  end

endmodule

// ===== hw/rtl/tlr_job_fifo.sv =====
// Two-entry queue of segment jobs between front and back end.
// Depends on tlr_pkg.
module tlr_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tlr_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output tlr_pkg::job_t data_o
);

  tlr_pkg::job_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== hw/rtl/tlr_back.sv =====
// Back end: emits the held point, the interpolated points and the new point.
// Two multiplications (StMulX, StMulY) and two bit-serial dividers; depends on tlr_pkg.
module tlr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_empty_i,
  input  tlr_pkg::job_t job_i,
  output logic          job_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tlr_pkg::out_t result_o
);

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StFirst  = 8'b0000_0010,
    StDcalc  = 8'b0000_0100,
    StMulX   = 8'b0000_1000,
    StMulY   = 8'b0001_0000,
    StDiv    = 8'b0010_0000,
    StInterp = 8'b0100_0000,
    StLast   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  tlr_pkg::job_t job_q;
  logic [tlr_pkg::CntW-1:0] j_q;
  logic [31:0] d_q, den_q;
  logic [32:0] magx_q, magy_q;
  logic        negx_q, negy_q;
  logic [tlr_pkg::ProdW-1:0] dvdx_q, dvdy_q;
  logic [31:0] remx_q, remy_q;
  logic [33:0] qx_q, qy_q;
  logic [tlr_pkg::DivCntW-1:0] div_cnt_q;
  tlr_pkg::out_t out_q, out_d;
  logic out_valid_q, slot_free, load;

  logic [15:0] sec;
  logic [32:0] diffx, diffy, trialx, trialy;
  logic        gex, gey;
  logic signed [33:0] basex, basey;

  assign slot_free = !out_valid_q || pop_i;
  assign empty_o   = !out_valid_q;
  assign result_o  = out_q;
  assign job_pop_o = (state_q == StIdle) && !job_empty_i;

  always_comb begin
    sec   = job_q.prev_time[31:16] + 16'd1 + {10'd0, j_q};
    diffx = {job_q.cur_x[31], job_q.cur_x} - {job_q.prev_x[31], job_q.prev_x};
    diffy = {job_q.cur_y[31], job_q.cur_y} - {job_q.prev_y[31], job_q.prev_y};
    trialx = {remx_q, dvdx_q[tlr_pkg::ProdW-1]};
    trialy = {remy_q, dvdy_q[tlr_pkg::ProdW-1]};
    gex = trialx >= {1'b0, den_q};
    gey = trialy >= {1'b0, den_q};
  end

  // Truncate toward zero: step back toward zero when the fraction is dropped.
  function automatic logic signed [33:0] finish(input logic [31:0] a, input logic neg,
                                                input logic [33:0] q, input logic rem_nz);
    logic signed [33:0] av, b;
    av = {{2{a[31]}}, a};
    b  = neg ? (av - $signed(q)) : (av + $signed(q));
    if (rem_nz && !neg && b < 0) b = b + 34'sd1;
    if (rem_nz && neg && b > 0) b = b - 34'sd1;
    return b;
  endfunction

  always_comb begin
    basex = finish(job_q.prev_x, negx_q, qx_q, remx_q != 32'd0);
    basey = finish(job_q.prev_y, negy_q, qy_q, remy_q != 32'd0);
  end

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    out_d   = out_q;
    case (state_q)
      StIdle: begin
        if (!job_empty_i) begin
          state_d = job_i.emit_first ? StFirst :
                    ((job_i.n_interp != '0) ? StDcalc : StLast);
        end
      end
      StFirst: begin
        if (slot_free) begin
          load  = 1'b1;
          out_d = '{out_time: job_q.prev_time, out_x: job_q.prev_x, out_y: job_q.prev_y,
                    point_kind: 1'b0, gap_clipped: job_q.clipped, last_of_run: 1'b0};
          state_d = (job_q.n_interp != '0) ? StDcalc : StLast;
        end
      end
      StDcalc: state_d = StMulX;
      StMulX:  state_d = StMulY;
      StMulY:  state_d = StDiv;
      StDiv: begin
        if (div_cnt_q == tlr_pkg::DivCntW'(tlr_pkg::ProdW - 1)) state_d = StInterp;
      end
      StInterp: begin
        if (slot_free) begin
          load  = 1'b1;
          out_d = '{out_time: {sec, 16'd0}, out_x: basex[31:0], out_y: basey[31:0],
                    point_kind: 1'b1, gap_clipped: job_q.clipped, last_of_run: 1'b0};
          state_d = (j_q + 1'b1 == job_q.n_interp) ? StLast : StDcalc;
        end
      end
      StLast: begin
        if (slot_free) begin
          load  = 1'b1;
          out_d = '{out_time: job_q.cur_time, out_x: job_q.cur_x, out_y: job_q.cur_y,
                    point_kind: 1'b0, gap_clipped: job_q.clipped, last_of_run: 1'b1};
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      j_q         <= '0;
      div_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
      if (state_q == StIdle) j_q <= '0;
      else if (state_q == StInterp && slot_free) j_q <= j_q + 1'b1;
      if (state_q == StDiv) div_cnt_q <= div_cnt_q + 1'b1;
      else div_cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= out_d;
    if (job_pop_o) job_q <= job_i;
    case (state_q)
      StDcalc: begin
        d_q    <= {sec, 16'd0} - job_q.prev_time;
        den_q  <= job_q.cur_time - job_q.prev_time;
        negx_q <= diffx[32];
        negy_q <= diffy[32];
        magx_q <= diffx[32] ? (33'd0 - diffx) : diffx;
        magy_q <= diffy[32] ? (33'd0 - diffy) : diffy;
      end
      StMulX: begin
        dvdx_q <= tlr_pkg::ProdW'(d_q) * tlr_pkg::ProdW'(magx_q);
        remx_q <= '0;
        qx_q   <= '0;
      end
      StMulY: begin
        dvdy_q <= tlr_pkg::ProdW'(d_q) * tlr_pkg::ProdW'(magy_q);
        remy_q <= '0;
        qy_q   <= '0;
      end
      StDiv: begin
        dvdx_q <= {dvdx_q[tlr_pkg::ProdW-2:0], 1'b0};
        dvdy_q <= {dvdy_q[tlr_pkg::ProdW-2:0], 1'b0};
        remx_q <= gex ? 32'(trialx - {1'b0, den_q}) : trialx[31:0];
        remy_q <= gey ? 32'(trialy - {1'b0, den_q}) : trialy[31:0];
        qx_q   <= {qx_q[32:0], gex};
        qy_q   <= {qy_q[32:0], gey};
      end
      default: ;
    endcase
  end

endmodule
